>>> src/unix_seconds_to_utc_calendar_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the UTC calendar core
// Shared forms of the concurrent checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_TO_UTC_CALENDAR_CORE_DEFINES_SVH
`define UNIX_SECONDS_TO_UTC_CALENDAR_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define UCAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ucal_pkg.sv
// ----------------------------------------------------------------------------
// UTC calendar package
// Constants, the pipeline stage record and the month offset table.
// ----------------------------------------------------------------------------
package ucal_pkg;

  localparam int NUM_STAGES = 9;

  localparam logic [25:0] DAY_RECIP      = 26'd50903317;
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [19:0] EPOCH_DAYS     = 20'd719468;
  localparam logic [19:0] ERA5_START     = 20'd730485;
  localparam logic [19:0] ERA4_START     = 20'd584388;
  localparam logic [16:0] WEEK_RECIP     = 17'd74899;
  localparam logic [15:0] WEEK_OFFSET    = 16'd4;
  localparam logic [17:0] HOUR_RECIP     = 18'd149131;
  localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
  localparam logic [18:0] Q1460_RECIP    = 19'd367720;
  localparam logic [12:0] MIN_RECIP      = 13'd4370;
  localparam logic [11:0] SECS_PER_MIN   = 12'd60;
  localparam logic [18:0] YEAR_RECIP     = 19'd367720;
  localparam logic [11:0] MP_RECIP       = 12'd3427;
  localparam logic [17:0] DOE_CENT1      = 18'd36524;
  localparam logic [17:0] DOE_CENT2      = 18'd73048;
  localparam logic [17:0] DOE_CENT3      = 18'd109572;
  localparam logic [17:0] DOE_ERA_END    = 18'd146096;
  localparam logic [8:0]  YOE_CENT1      = 9'd100;
  localparam logic [8:0]  YOE_CENT2      = 9'd200;
  localparam logic [8:0]  YOE_CENT3      = 9'd300;
  localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
  localparam logic [8:0]  JAN_FIRST_DOY  = 9'd306;
  localparam logic [8:0]  MAR_FIRST_YDAY = 9'd59;
  localparam logic [3:0]  MP_JANUARY     = 4'd10;
  localparam logic [9:0]  ERA5_YEAR_ADJ  = 10'd100;
  localparam logic [9:0]  ERA4_YEAR_ADJ  = 10'd724;
  localparam logic [7:0]  NON_LEAP_CENT  = 8'd200;

  typedef struct packed {
    logic [31:0] secs;
    logic [15:0] days;
    logic [16:0] sod;
    logic [11:0] rem;
    logic [17:0] doe;
    logic        era5;
    logic [15:0] wsum;
    logic [13:0] wquo;
    logic [6:0]  q1460;
    logic [17:0] ysum;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [3:0]  mp;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  month_day;
    logic [3:0]  month_index;
    logic [7:0]  years_since_1900;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
  } stage_t;

  // First day of each month, counted from March first.
  function automatic logic [8:0] mp_day_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

>>> src/ucal_in_if.sv
// ----------------------------------------------------------------------------
// UTC calendar input channel
// Valid/ready channel that carries one Unix timestamp per item.
// ----------------------------------------------------------------------------
interface ucal_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

>>> src/ucal_out_if.sv
// ----------------------------------------------------------------------------
// UTC calendar output channel
// Valid/ready channel that carries one broken-down UTC time per item.
// ----------------------------------------------------------------------------
interface ucal_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] month_day;
  logic [3:0] month_index;
  logic [7:0] years_since_1900;
  logic [2:0] weekday;
  logic [8:0] year_day;

  modport source (
    output valid, output second, output minute, output hour, output month_day,
    output month_index, output years_since_1900, output weekday, output year_day,
    input ready
  );
  modport sink (
    input valid, input second, input minute, input hour, input month_day,
    input month_index, input years_since_1900, input weekday, input year_day,
    output ready
  );
endinterface

>>> src/unix_seconds_to_utc_calendar_core.sv
// ----------------------------------------------------------------------------
// Unix seconds to UTC calendar core
// Converts a 32-bit Unix timestamp into broken-down UTC calendar time.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle while the output side does not
// stall. Items pass through nine register stages. Each stage holds one or two
// constant reciprocal multiplications, the corrections after them, or a short
// table lookup. Every stage has its own valid bit and loads whenever it is
// empty or its content moves on, so a stall on the output fills empty stages
// first and only then holds the input ready low.
module unix_seconds_to_utc_calendar_core (
  input logic      clk_i,
  input logic      rst_ni,
  ucal_in_if.sink  in_i,
  ucal_out_if.source out_o
);

  ucal_pkg::stage_t st_q [ucal_pkg::NUM_STAGES];
  ucal_pkg::stage_t st_d [ucal_pkg::NUM_STAGES];
  logic [ucal_pkg::NUM_STAGES-1:0] v_q;
  logic [ucal_pkg::NUM_STAGES-1:0] load;

  logic [50:0] day_prod;
  logic [32:0] day_secs;
  logic [19:0] z;
  logic        z_era5;
  logic [15:0] wsum;
  logic [32:0] wk_prod;
  logic [34:0] hr_prod;
  logic [36:0] q1460_prod;
  logic [15:0] wk7;
  logic [16:0] hour_secs;
  logic [1:0]  doe_cent;
  logic [24:0] mn_prod;
  logic [36:0] yoe_prod;
  logic [11:0] min_secs;
  logic [1:0]  yoe_cent;
  logic [17:0] yr_days;
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic        jan_feb;
  logic [9:0]  year_adj;
  logic        leap;

  always_comb begin
    load[ucal_pkg::NUM_STAGES-1] = !v_q[ucal_pkg::NUM_STAGES-1] || out_o.ready;
    for (int k = ucal_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !v_q[k] || load[k+1];
    end
  end

  assign in_i.ready = load[0];

  always_comb begin
    st_d[0] = '0;
    st_d[0].secs = in_i.unix_seconds;
    day_prod = 51'(in_i.unix_seconds[31:7]) * 51'(ucal_pkg::DAY_RECIP);
    st_d[0].days = day_prod[50:35];

    st_d[1] = st_q[0];
    day_secs = 33'(st_q[0].days) * 33'(ucal_pkg::SECS_PER_DAY);
    st_d[1].sod = st_q[0].secs[16:0] - day_secs[16:0];
    z = 20'(st_q[0].days) + ucal_pkg::EPOCH_DAYS;
    z_era5 = (z >= ucal_pkg::ERA5_START);
    st_d[1].era5 = z_era5;
    st_d[1].doe = z_era5 ? 18'(z - ucal_pkg::ERA5_START) : 18'(z - ucal_pkg::ERA4_START);
    wsum = st_q[0].days + ucal_pkg::WEEK_OFFSET;
    st_d[1].wsum = wsum;
    wk_prod = 33'(wsum) * 33'(ucal_pkg::WEEK_RECIP);
    st_d[1].wquo = wk_prod[32:19];

    st_d[2] = st_q[1];
    hr_prod = 35'(st_q[1].sod) * 35'(ucal_pkg::HOUR_RECIP);
    st_d[2].hour = hr_prod[33:29];
    q1460_prod = 37'(st_q[1].doe) * 37'(ucal_pkg::Q1460_RECIP);
    st_d[2].q1460 = q1460_prod[35:29];
    wk7 = {st_q[1].wquo[12:0], 3'b000} - {2'b00, st_q[1].wquo};
    st_d[2].weekday = 3'(st_q[1].wsum - wk7);

    st_d[3] = st_q[2];
    hour_secs = 17'(st_q[2].hour) * 17'(ucal_pkg::SECS_PER_HOUR);
    st_d[3].rem = st_q[2].sod[11:0] - hour_secs[11:0];
    doe_cent = 2'(st_q[2].doe >= ucal_pkg::DOE_CENT1) + 2'(st_q[2].doe >= ucal_pkg::DOE_CENT2)
             + 2'(st_q[2].doe >= ucal_pkg::DOE_CENT3);
    st_d[3].ysum = st_q[2].doe - 18'(st_q[2].q1460) + 18'(doe_cent)
                 - 18'(st_q[2].doe >= ucal_pkg::DOE_ERA_END);

    st_d[4] = st_q[3];
    mn_prod = 25'(st_q[3].rem) * 25'(ucal_pkg::MIN_RECIP);
    st_d[4].minute = mn_prod[23:18];
    yoe_prod = 37'(st_q[3].ysum) * 37'(ucal_pkg::YEAR_RECIP);
    st_d[4].yoe = yoe_prod[35:27];

    st_d[5] = st_q[4];
    min_secs = 12'(st_q[4].minute) * ucal_pkg::SECS_PER_MIN;
    st_d[5].second = 6'(st_q[4].rem - min_secs);
    yoe_cent = 2'(st_q[4].yoe >= ucal_pkg::YOE_CENT1) + 2'(st_q[4].yoe >= ucal_pkg::YOE_CENT2)
             + 2'(st_q[4].yoe >= ucal_pkg::YOE_CENT3);
    yr_days = 18'(st_q[4].yoe) * ucal_pkg::DAYS_PER_YEAR + 18'(st_q[4].yoe[8:2])
            - 18'(yoe_cent);
    st_d[5].doy = 9'(st_q[4].doe - yr_days);

    st_d[6] = st_q[5];
    mp_num = {st_q[5].doy, 2'b00} + 11'(st_q[5].doy) + 11'd2;
    mp_prod = 23'(mp_num) * 23'(ucal_pkg::MP_RECIP);
    st_d[6].mp = mp_prod[22:19];

    st_d[7] = st_q[6];
    st_d[7].month_day = 5'(st_q[6].doy - ucal_pkg::mp_day_offset(st_q[6].mp) + 9'd1);
    jan_feb = (st_q[6].mp >= ucal_pkg::MP_JANUARY);
    st_d[7].month_index = jan_feb ? st_q[6].mp - ucal_pkg::MP_JANUARY : st_q[6].mp + 4'd2;
    year_adj = 10'(st_q[6].yoe)
             + (st_q[6].era5 ? ucal_pkg::ERA5_YEAR_ADJ : ucal_pkg::ERA4_YEAR_ADJ)
             + 10'(jan_feb);
    st_d[7].years_since_1900 = year_adj[7:0];

    st_d[8] = st_q[7];
    leap = (st_q[7].years_since_1900[1:0] == 2'b00)
        && (st_q[7].years_since_1900 != ucal_pkg::NON_LEAP_CENT);
    st_d[8].year_day = (st_q[7].doy >= ucal_pkg::JAN_FIRST_DOY)
                     ? st_q[7].doy - ucal_pkg::JAN_FIRST_DOY
                     : st_q[7].doy + ucal_pkg::MAR_FIRST_YDAY + 9'(leap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < ucal_pkg::NUM_STAGES; k++) begin
        if (load[k]) begin
          v_q[k] <= (k == 0) ? in_i.valid : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ucal_pkg::NUM_STAGES; k++) begin
      if (load[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_o.valid            = v_q[ucal_pkg::NUM_STAGES-1];
  assign out_o.second           = st_q[ucal_pkg::NUM_STAGES-1].second;
  assign out_o.minute           = st_q[ucal_pkg::NUM_STAGES-1].minute;
  assign out_o.hour             = st_q[ucal_pkg::NUM_STAGES-1].hour;
  assign out_o.month_day        = st_q[ucal_pkg::NUM_STAGES-1].month_day;
  assign out_o.month_index      = st_q[ucal_pkg::NUM_STAGES-1].month_index;
  assign out_o.years_since_1900 = st_q[ucal_pkg::NUM_STAGES-1].years_since_1900;
  assign out_o.weekday          = st_q[ucal_pkg::NUM_STAGES-1].weekday;
  assign out_o.year_day         = st_q[ucal_pkg::NUM_STAGES-1].year_day;

endmodule

>>> src/ucal_checker.sv
// ----------------------------------------------------------------------------
// UTC calendar port checker
// Checks handshake behavior and pipeline timing seen at the core's ports.
// ----------------------------------------------------------------------------
`include "unix_seconds_to_utc_calendar_core_defines.svh"

module ucal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [45:0] out_payload_i
);

  `UCAL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_i), "Stalled output item changed or vanished.")
  `UCAL_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i, "Input not ready while the output stage is empty.")
  `UCAL_ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_i && out_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i, "Item did not reach the output after nine cycles.")

endmodule

bind unix_seconds_to_utc_calendar_core ucal_checker u_ucal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i ({out_o.second, out_o.minute, out_o.hour, out_o.month_day,
                   out_o.month_index, out_o.years_since_1900, out_o.weekday,
                   out_o.year_day})
);
